/* sv/gdoy_pkg.sv */
// gdoy_pkg: types, constants and calendar tables for the day-of-year converter
// standalone, no dependencies; used by gregorian_day_of_year_converter_unit
`default_nettype none

package gdoy_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MONTH = 3'd1,
        ST_BAD_DAY   = 3'd2,
        ST_PAST_END  = 3'd3,
        ST_BAD_YDAY  = 3'd4
    } status_t;

    // operation codes
    localparam logic OP_DATE_TO_YDAY = 1'b0;
    localparam logic OP_YDAY_TO_DATE = 1'b1;

    localparam int MONTHS = 12;
    localparam int MAX_MONTH_DAYS = 31;
    localparam logic [8:0] COMMON_YEAR_DAYS = 9'd365;

    // divisible-by-25 test on a 16-bit value: v * inv(25) mod 2^16 <= (2^16-1)/25
    localparam logic [15:0] INV25 = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    // days before the first day of a month, common year (month 13 = full year)
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] r;
        begin
            case (m)
                4'd1:    r = 9'd0;
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd59;
                4'd4:    r = 9'd90;
                4'd5:    r = 9'd120;
                4'd6:    r = 9'd151;
                4'd7:    r = 9'd181;
                4'd8:    r = 9'd212;
                4'd9:    r = 9'd243;
                4'd10:   r = 9'd273;
                4'd11:   r = 9'd304;
                4'd12:   r = 9'd334;
                4'd13:   r = 9'd365;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // length of a month; zero for codes that name no month
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        begin
            case (m)
                4'd2:                                 r = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:              r = 5'd30;
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
                4'd12:                                r = 5'd31;
                default:                              r = 5'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/gregorian_day_of_year_converter_unit.sv */
// gregorian_day_of_year_converter_unit: date <-> day-of-year conversion, two stages
// depends on gdoy_pkg (status codes, op codes, calendar tables)
//
// usage
//   input channel: in_valid / in_stall with op, year, month, day, year_day.
//   op 0 turns year, month and day into day_number; op 1 turns year and
//   year_day into month_out and day_out. leap_year is always given; status
//   is nonzero for a bad operand, and the conversion outputs are then zero.
//   output channel: out_valid / out_stall with the five result fields.
//   a beat is taken at a clock edge with valid high and stall low.
//   a beat passes the input register, then the result register.
//   throughput: one beat per cycle while the receiver does not stall, set
//   by the single pass of leap test and table lookups between the two registers.
//   when the receiver stalls, the result register holds its beat and the
//   input register, if empty, still takes one more beat; after that in_stall is
//   raised until the result moves on.
//   reset (rst_n low, asynchronous) empties both registers; no item is
//   lost or repeated across a stall.
`default_nettype none

module gregorian_day_of_year_converter_unit #(
    parameter int YEAR_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [15:0] year,
    input  wire logic [3:0]  month,
    input  wire logic [5:0]  day,
    input  wire logic [8:0]  year_day,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [8:0]       day_number,
    output logic [3:0]       month_out,
    output logic [4:0]       day_out,
    output logic             leap_year,
    output logic [2:0]       status
);

    // bits of the year that take part in the leap test
    localparam int LEAP_W = (YEAR_WIDTH < 16) ? YEAR_WIDTH : 16;
    localparam logic [15:0] YEAR_MASK = 16'((32'd1 << LEAP_W) - 32'd1);

    // input register
    logic        s1_valid_reg;
    logic        op_reg;
    logic [15:0] year_reg;
    logic [3:0]  month_reg;
    logic [5:0]  day_reg;
    logic [8:0]  yday_reg;

    // result register
    logic        out_valid_reg;
    logic [8:0]  dnum_reg,   dnum_next;
    logic [3:0]  mout_reg,   mout_next;
    logic [4:0]  dout_reg,   dout_next;
    logic        leap_reg,   leap_next;
    gdoy_pkg::status_t status_reg, status_next;

    logic out_adv;
    logic in_take;

    // pipeline control
    assign out_adv  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg    <= op;
            year_reg  <= year;
            month_reg <= month;
            day_reg   <= day;
            yday_reg  <= year_day;
        end
    end

    // leap test: by 4 and not by 100, or by 400
    logic [15:0] year_used;
    logic [15:0] year_scaled;
    logic        div25;

    assign year_used   = year_reg & YEAR_MASK;
    assign year_scaled = year_used * gdoy_pkg::INV25;
    assign div25       = (year_scaled <= gdoy_pkg::DIV25_LIMIT);
    assign leap_next   = ((year_used[1:0] == 2'd0) && !div25)
                      || ((year_used[3:0] == 4'd0) && div25);

    // month search for year-day input: count month ends before the day
    logic [3:0] ends_before;
    logic [3:0] found_month;
    logic [8:0] month_start;
    logic [8:0] yd_limit;

    always_comb
    begin
        ends_before = 4'd0;
        for (int m = 1; m < gdoy_pkg::MONTHS; m++)
        begin
            if (yday_reg > (gdoy_pkg::days_before(4'(m + 1))
                            + {8'd0, (leap_next && (m >= 2))}))
            begin
                ends_before = ends_before + 4'd1;
            end
        end
    end

    assign found_month = ends_before + 4'd1;
    assign month_start = gdoy_pkg::days_before(found_month)
                       + {8'd0, (leap_next && (found_month > 4'd2))};
    assign yd_limit    = gdoy_pkg::COMMON_YEAR_DAYS + {8'd0, leap_next};

    // conversion and checks
    always_comb
    begin
        dnum_next   = 9'd0;
        mout_next   = 4'd0;
        dout_next   = 5'd0;
        status_next = gdoy_pkg::ST_OK;
        if (op_reg == gdoy_pkg::OP_DATE_TO_YDAY)
        begin
            if (month_reg < 4'd1 || month_reg > 4'(gdoy_pkg::MONTHS))
            begin
                status_next = gdoy_pkg::ST_BAD_MONTH;
            end
            else if (day_reg < 6'd1 || day_reg > 6'(gdoy_pkg::MAX_MONTH_DAYS))
            begin
                status_next = gdoy_pkg::ST_BAD_DAY;
            end
            else if (day_reg > {1'b0, gdoy_pkg::month_len(month_reg, leap_next)})
            begin
                status_next = gdoy_pkg::ST_PAST_END;
            end
            else
            begin
                dnum_next = gdoy_pkg::days_before(month_reg) + {3'd0, day_reg}
                          + {8'd0, (leap_next && (month_reg > 4'd2))};
            end
        end
        else
        begin
            if (yday_reg < 9'd1 || yday_reg > yd_limit)
            begin
                status_next = gdoy_pkg::ST_BAD_YDAY;
            end
            else
            begin
                mout_next = found_month;
                dout_next = 5'(yday_reg - month_start);
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            dnum_reg   <= dnum_next;
            mout_reg   <= mout_next;
            dout_reg   <= dout_next;
            leap_reg   <= leap_next;
            status_reg <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign day_number = dnum_reg;
    assign month_out  = mout_reg;
    assign day_out    = dout_reg;
    assign leap_year  = leap_reg;
    assign status     = status_reg;

    // checks
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != gdoy_pkg::ST_OK)
            |-> (day_number == 9'd0 && month_out == 4'd0 && day_out == 5'd0))
        else $error("error result with nonzero outputs");

    a_one_conversion: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (day_number == 9'd0 || month_out == 4'd0))
        else $error("both conversions filled in one result");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && month_out != 4'd0)
            |-> (month_out <= 4'd12 && day_out != 5'd0))
        else $error("month search out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with the result side free");

endmodule

`default_nettype wire

/* tb/gregorian_day_of_year_converter_unit_tb.sv */
// gregorian_day_of_year_converter_unit_tb: self-checking bench for the date <-> day-of-year unit
// depends on gdoy_pkg and gregorian_day_of_year_converter_unit; a scoreboard class predicts
// each result beat, and plain tasks drive randomized traffic with stalls on both channels
`default_nettype none

// expected result of one conversion
typedef struct packed {
    logic [8:0]       day_number;
    logic [3:0]       month_out;
    logic [4:0]       day_out;
    logic             leap;
    gdoy_pkg::status_t status;
} conv_result_t;

class calendar_scoreboard;
    conv_result_t expected_q[$];
    int errors;
    int to_yday_beats;
    int to_date_beats;
    int leap_beats;
    int status_hits[5];

    function new();
        errors = 0;
        to_yday_beats = 0;
        to_date_beats = 0;
        leap_beats = 0;
        foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // month lengths, own copy of the calendar
    function int days_in_month(int m, bit leap);
        case (m)
            2:              return leap ? 29 : 28;
            4, 6, 9, 11:    return 30;
            default:        return 31;
        endcase
    endfunction

    // gregorian conversion in both directions
    function conv_result_t convert_date(logic opsel, logic [15:0] yr, logic [3:0] mo,
                                        logic [5:0] dy, logic [8:0] yd);
        conv_result_t r;
        bit leap;
        int total;
        int rest;
        int m;
        r = '0;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        r.leap = leap;
        r.status = gdoy_pkg::ST_OK;
        if (opsel == gdoy_pkg::OP_DATE_TO_YDAY) begin
            if (mo < 1 || mo > 12) begin
                r.status = gdoy_pkg::ST_BAD_MONTH;
            end else if (dy < 1 || dy > 31) begin
                r.status = gdoy_pkg::ST_BAD_DAY;
            end else if (int'(dy) > days_in_month(int'(mo), leap)) begin
                r.status = gdoy_pkg::ST_PAST_END;
            end else begin
                total = int'(dy);
                for (m = 1; m < int'(mo); m++) total += days_in_month(m, leap);
                r.day_number = total[8:0];
            end
        end else begin
            if (yd < 1 || int'(yd) > 365 + int'(leap)) begin
                r.status = gdoy_pkg::ST_BAD_YDAY;
            end else begin
                rest = int'(yd);
                m = 1;
                while (m < 12 && rest > days_in_month(m, leap)) begin
                    rest -= days_in_month(m, leap);
                    m++;
                end
                r.month_out = m[3:0];
                r.day_out = rest[4:0];
            end
        end
        return r;
    endfunction

    // accepted input beat: queue its prediction
    function void note_input(logic opsel, logic [15:0] yr, logic [3:0] mo,
                             logic [5:0] dy, logic [8:0] yd);
        conv_result_t r;
        r = convert_date(opsel, yr, mo, dy, yd);
        expected_q.push_back(r);
        if (opsel == gdoy_pkg::OP_DATE_TO_YDAY) to_yday_beats++;
        else to_date_beats++;
        if (r.leap) leap_beats++;
        status_hits[r.status]++;
    endfunction

    // accepted result beat: compare against the oldest prediction
    function void check_result(logic [8:0] dn, logic [3:0] mo, logic [4:0] dy,
                               logic leap, logic [2:0] st);
        conv_result_t r;
        if (expected_q.size() == 0) begin
            $error("result beat with no expected result pending");
            errors++;
            return;
        end
        r = expected_q.pop_front();
        if (dn !== r.day_number) begin
            $error("day_number: expected %0d, got %0d", r.day_number, dn);
            errors++;
        end
        if (mo !== r.month_out) begin
            $error("month_out: expected %0d, got %0d", r.month_out, mo);
            errors++;
        end
        if (dy !== r.day_out) begin
            $error("day_out: expected %0d, got %0d", r.day_out, dy);
            errors++;
        end
        if (leap !== r.leap) begin
            $error("leap_year: expected %0d, got %0d", r.leap, leap);
            errors++;
        end
        if (st !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, st);
            errors++;
        end
    endfunction

    function int outstanding();
        return expected_q.size();
    endfunction
endclass

module gregorian_day_of_year_converter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1750;
    localparam int IDLE_LIMIT = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = 1'b0;
    logic [15:0] year = '0;
    logic [3:0]  month = '0;
    logic [5:0]  day = '0;
    logic [8:0]  year_day = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [8:0]  day_number;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic        leap_year;
    logic [2:0]  status;

    calendar_scoreboard sb = new();
    bit quiet_in = 1'b0;
    bit quiet_out = 1'b0;
    int idle_cycles = 0;

    gregorian_day_of_year_converter_unit uut (.*);

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // drive one input beat and hold it until taken
    task automatic send_beat(input logic o, input logic [15:0] y, input logic [3:0] m,
                             input logic [5:0] d, input logic [8:0] yd);
        op <= o;
        year <= y;
        month <= m;
        day <= d;
        year_day <= yd;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_input(o, y, m, d, yd);
    endtask

    // random idle cycles between input beats
    task automatic sender_gap();
        int n;
        n = quiet_in ? 0 : $urandom_range(0, 9);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // hold off the sender until every expected result is back
    task automatic wait_for_drain();
        if (sb.outstanding() != 0) begin
            in_valid <= 1'b0;
            while (sb.outstanding() != 0) @(posedge clk);
        end
    endtask

    // year biased toward the leap rule boundaries
    function automatic logic [15:0] pick_year();
        int v;
        case ($urandom_range(0, 4))
            0:       v = $urandom_range(0, 65535);
            1:       v = 400 * $urandom_range(0, 163);
            2:       v = 100 * $urandom_range(0, 655);
            3:       v = 4 * $urandom_range(0, 16383);
            default: v = $urandom_range(1890, 2110);
        endcase
        return v[15:0];
    endfunction

    // one random item, mostly well formed
    task automatic random_item();
        logic        o;
        logic [15:0] y;
        logic [3:0]  m;
        logic [5:0]  d;
        logic [8:0]  yd;
        int          pick;
        o = 1'($urandom_range(0, 1));
        y = pick_year();
        m = 4'($urandom_range(0, 15));
        d = 6'($urandom_range(0, 63));
        yd = 9'($urandom_range(0, 511));
        pick = $urandom_range(0, 99);
        if (o == gdoy_pkg::OP_DATE_TO_YDAY) begin
            if (pick < 85) begin
                m = 4'($urandom_range(1, 12));
                d = 6'($urandom_range(1, 31));
            end
        end else if (pick < 12) begin
            case ($urandom_range(0, 5))
                0:       yd = 9'd1;
                1:       yd = 9'd59;
                2:       yd = 9'd60;
                3:       yd = 9'd365;
                4:       yd = 9'd366;
                default: yd = 9'd367;
            endcase
        end else if (pick < 88) begin
            yd = 9'($urandom_range(1, 366));
        end
        send_beat(o, y, m, d, yd);
    endtask

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(day_number, month_out, day_out, leap_year, status);
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: random stall before each result, with stall-free stretches
    initial begin
        int n;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            n = quiet_out ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
            taken++;
            if (taken % 100 == 0) quiet_out = !quiet_out;
        end
    end

    // stimulus
    initial begin
        int i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // month, day and past-end checks
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2023, 4'd0, 6'd10, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2023, 4'd13, 6'd10, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2023, 4'd15, 6'd63, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2023, 4'd5, 6'd0, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2023, 4'd5, 6'd32, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2023, 4'd5, 6'd63, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2023, 4'd2, 6'd29, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2024, 4'd2, 6'd29, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2024, 4'd2, 6'd30, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2023, 4'd4, 6'd31, 9'($urandom));
        // year ends and leap rule corners
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2023, 4'd1, 6'd1, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2023, 4'd12, 6'd31, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2024, 4'd12, 6'd31, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd1900, 4'd3, 6'd1, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd2000, 4'd3, 6'd1, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'd0, 4'd3, 6'd1, 9'($urandom));
        sender_gap(); send_beat(gdoy_pkg::OP_DATE_TO_YDAY, 16'hFFFF, 4'd12, 6'd31, 9'($urandom));
        // day of year to date, including the leap day and bad year days
        sender_gap();
        send_beat(gdoy_pkg::OP_YDAY_TO_DATE, 16'd2023, 4'($urandom), 6'($urandom), 9'd0);
        sender_gap();
        send_beat(gdoy_pkg::OP_YDAY_TO_DATE, 16'd2023, 4'($urandom), 6'($urandom), 9'd1);
        sender_gap();
        send_beat(gdoy_pkg::OP_YDAY_TO_DATE, 16'd2023, 4'($urandom), 6'($urandom), 9'd365);
        sender_gap();
        send_beat(gdoy_pkg::OP_YDAY_TO_DATE, 16'd2023, 4'($urandom), 6'($urandom), 9'd366);
        sender_gap();
        send_beat(gdoy_pkg::OP_YDAY_TO_DATE, 16'd2024, 4'($urandom), 6'($urandom), 9'd366);
        sender_gap();
        send_beat(gdoy_pkg::OP_YDAY_TO_DATE, 16'd2024, 4'($urandom), 6'($urandom), 9'd60);
        sender_gap();
        send_beat(gdoy_pkg::OP_YDAY_TO_DATE, 16'd2023, 4'($urandom), 6'($urandom), 9'd60);
        sender_gap();
        send_beat(gdoy_pkg::OP_YDAY_TO_DATE, 16'd2100, 4'($urandom), 6'($urandom), 9'd511);
        wait_for_drain();

        // random traffic, with burst stretches and one drain in the middle
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 150 == 0) quiet_in = ($urandom_range(0, 2) == 0);
            if (i == RANDOM_ITEMS / 2) wait_for_drain();
            else sender_gap();
            random_item();
        end
        in_valid <= 1'b0;

        // drain, then allow for the pipeline latency
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("covered %0d date-to-day-of-year and %0d day-of-year-to-date beats, %0d leap",
                 sb.to_yday_beats, sb.to_date_beats, sb.leap_beats);
        $display("statuses: ok %0d, bad month %0d, bad day %0d, past end %0d, bad year day %0d",
                 sb.status_hits[gdoy_pkg::ST_OK], sb.status_hits[gdoy_pkg::ST_BAD_MONTH],
                 sb.status_hits[gdoy_pkg::ST_BAD_DAY], sb.status_hits[gdoy_pkg::ST_PAST_END],
                 sb.status_hits[gdoy_pkg::ST_BAD_YDAY]);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
